/* hw/rtl/vn_pkg.sv */
package vn_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int THR_W      = 33;
    localparam int OUT_W      = 16;
    localparam int M_W        = 15;
    localparam int SQ_W       = 2 * COMP_WIDTH - 1;
    localparam int SUM_W      = 2 * COMP_WIDTH + 1;
    localparam int TGT_W      = 2 * COMP_WIDTH + 29;
    localparam int WIDE_W     = 2 * COMP_WIDTH + 34;
    localparam int CMP_W      = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int N_LANES    = 4;
    localparam int B_SH       = M_W + 1;
    localparam int D_SH       = 2 * M_W;
    localparam int TGT_SH     = 30;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);
    localparam logic [M_W-1:0]   ONE_Q14   = M_W'(16384);

    typedef struct packed {
        logic [COMP_WIDTH-1:0] mag;
        logic                  neg;
        logic [SQ_W-1:0]       sq;
    } t_sq;

    typedef struct packed {
        logic                     neg;
        logic [TGT_W-1:0]         tgt;
        logic signed [WIDE_W-1:0] acc;
        logic signed [WIDE_W-1:0] bs;
        logic [M_W-1:0]           m;
    } t_lane;

    typedef struct packed {
        t_lane [N_LANES-1:0]      lane;
        logic                     too_short;
        logic signed [WIDE_W-1:0] d2;
        logic [M_W-1:0]           bitv;
    } t_item;

endpackage

/* hw/rtl/vn_in_if.sv */
interface vn_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vn_pkg::COMP_WIDTH-1:0] comp_x;
    logic signed [vn_pkg::COMP_WIDTH-1:0] comp_y;
    logic signed [vn_pkg::COMP_WIDTH-1:0] comp_z;
    logic signed [vn_pkg::COMP_WIDTH-1:0] comp_w;

    modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
    modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

/* hw/rtl/vn_out_if.sv */
interface vn_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [vn_pkg::OUT_W-1:0] unit_x;
    logic signed [vn_pkg::OUT_W-1:0] unit_y;
    logic signed [vn_pkg::OUT_W-1:0] unit_z;
    logic signed [vn_pkg::OUT_W-1:0] unit_w;
    logic                            too_short;

    modport source (output valid, unit_x, unit_y, unit_z, unit_w, too_short, input ready);
    modport sink (input valid, unit_x, unit_y, unit_z, unit_w, too_short, output ready);
endinterface

/* hw/rtl/vn_cfg_if.sv */
interface vn_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [vn_pkg::THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/vn_front.sv */
module vn_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    vn_in_if.sink                    i_vec,
    input  logic [vn_pkg::THR_W-1:0] i_thr,
    output logic                     o_valid,
    input  logic                     i_ready,
    output vn_pkg::t_item            o_item
);

    logic                               r_v1;
    logic                               r_v2;
    vn_pkg::t_sq [vn_pkg::N_LANES-1:0]  r_sq;
    vn_pkg::t_sq [vn_pkg::N_LANES-1:0]  n_sq;
    vn_pkg::t_item                      r_item;
    vn_pkg::t_item                      n_item;
    logic [vn_pkg::COMP_WIDTH-1:0]      w_raw [vn_pkg::N_LANES];
    logic [vn_pkg::SUM_W-1:0]           w_sum;
    logic [vn_pkg::CMP_W-1:0]           w_sum_x;
    logic [vn_pkg::CMP_W-1:0]           w_thr_x;
    logic signed [vn_pkg::WIDE_W-1:0]   w_s;
    logic                               w_s1_ready;
    logic                               w_s2_ready;

    assign w_s2_ready  = ~r_v2 | i_ready;
    assign w_s1_ready  = ~r_v1 | w_s2_ready;
    assign i_vec.ready = w_s1_ready;
    assign o_valid     = r_v2;
    assign o_item      = r_item;

    assign w_raw[0] = i_vec.comp_x;
    assign w_raw[1] = i_vec.comp_y;
    assign w_raw[2] = i_vec.comp_z;
    assign w_raw[3] = i_vec.comp_w;

    always_comb begin
        for (int k = 0; k < vn_pkg::N_LANES; k++) begin
            n_sq[k].neg = w_raw[k][vn_pkg::COMP_WIDTH-1];
            n_sq[k].mag = n_sq[k].neg ? (~w_raw[k] + 1'b1) : w_raw[k];
            n_sq[k].sq  = vn_pkg::SQ_W'({{vn_pkg::COMP_WIDTH{1'b0}}, n_sq[k].mag}
                          * {{vn_pkg::COMP_WIDTH{1'b0}}, n_sq[k].mag});
        end
    end

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < vn_pkg::N_LANES; k++) begin
            w_sum = w_sum + vn_pkg::SUM_W'(r_sq[k].sq);
        end
        w_sum_x = vn_pkg::CMP_W'(w_sum);
        w_thr_x = vn_pkg::CMP_W'(i_thr);
        w_s     = vn_pkg::WIDE_W'(w_sum);

        n_item.too_short = (w_sum == '0) || (w_sum_x < w_thr_x);
        n_item.d2        = w_s <<< vn_pkg::D_SH;
        n_item.bitv      = {1'b1, {(vn_pkg::M_W-1){1'b0}}};
        for (int k = 0; k < vn_pkg::N_LANES; k++) begin
            n_item.lane[k].neg = r_sq[k].neg;
            n_item.lane[k].tgt = vn_pkg::TGT_W'(r_sq[k].sq) << vn_pkg::TGT_SH;
            n_item.lane[k].acc = w_s;
            n_item.lane[k].bs  = -(w_s <<< vn_pkg::B_SH);
            n_item.lane[k].m   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_v1 <= i_vec.valid;
            end
            if (w_s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_vec.valid) begin
            r_sq <= n_sq;
        end
        if (w_s2_ready && r_v1) begin
            r_item <= n_item;
        end
    end

endmodule

/* hw/rtl/vn_cell.sv */
module vn_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vn_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output vn_pkg::t_item o_item
);

    // one result bit per cell, all four lanes side by side
    logic                             r_v;
    vn_pkg::t_item                    r_item;
    vn_pkg::t_item                    n_item;
    logic signed [vn_pkg::WIDE_W-1:0] w_cand [vn_pkg::N_LANES];
    logic signed [vn_pkg::WIDE_W-1:0] w_tgt  [vn_pkg::N_LANES];
    logic                             w_take [vn_pkg::N_LANES];

    assign o_ready = ~r_v | i_ready;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_comb begin
        n_item = i_item;
        for (int k = 0; k < vn_pkg::N_LANES; k++) begin
            w_cand[k] = i_item.lane[k].acc + i_item.lane[k].bs + i_item.d2;
            w_tgt[k]  = vn_pkg::WIDE_W'(i_item.lane[k].tgt);
            w_take[k] = ~i_item.too_short && (w_cand[k] <= w_tgt[k]);
            if (w_take[k]) begin
                n_item.lane[k].acc = w_cand[k];
                n_item.lane[k].bs  = (i_item.lane[k].bs + (i_item.d2 <<< 1)) >>> 1;
                n_item.lane[k].m   = i_item.lane[k].m | i_item.bitv;
            end else begin
                n_item.lane[k].bs  = i_item.lane[k].bs >>> 1;
            end
        end
        n_item.d2   = i_item.d2 >>> 2;
        n_item.bitv = i_item.bitv >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

/* hw/rtl/vn_back.sv */
module vn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vn_pkg::t_item i_item,
    vn_out_if.source      o_unit
);

    logic                           r_v;
    logic [vn_pkg::OUT_W-1:0]       r_u [vn_pkg::N_LANES];
    logic [vn_pkg::OUT_W-1:0]       n_u [vn_pkg::N_LANES];
    logic                           r_short;
    logic [vn_pkg::M_W-1:0]         w_m [vn_pkg::N_LANES];

    assign o_ready          = ~r_v | o_unit.ready;
    assign o_unit.valid     = r_v;
    assign o_unit.unit_x    = r_u[0];
    assign o_unit.unit_y    = r_u[1];
    assign o_unit.unit_z    = r_u[2];
    assign o_unit.unit_w    = r_u[3];
    assign o_unit.too_short = r_short;

    always_comb begin
        for (int k = 0; k < vn_pkg::N_LANES; k++) begin
            w_m[k] = (i_item.lane[k].m > vn_pkg::ONE_Q14) ? vn_pkg::ONE_Q14
                                                         : i_item.lane[k].m;
            n_u[k] = i_item.lane[k].neg ? -vn_pkg::OUT_W'(w_m[k]) : vn_pkg::OUT_W'(w_m[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_u     <= n_u;
            r_short <= i_item.too_short;
        end
    end

endmodule

/* hw/rtl/vector4_normalize_top.sv */
// Pipeline: 2 front stages, 15 bit cells, 1 output stage; one item per cycle
// while o_unit.ready holds. Every stage has its own valid and stalls only when full.
// Each bit cell settles one result bit with a wide three-input add and compare per lane.
// Reset (i_rst_n, synchronous, active low) empties the pipeline and sets the
// zero threshold to 17.
module vector4_normalize_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vn_in_if.sink     i_vec,
    vn_cfg_if.sink    i_cfg,
    vn_out_if.source  o_unit
);

    logic [vn_pkg::THR_W-1:0] r_thr;
    logic                     w_v    [vn_pkg::M_W+1];
    logic                     w_r    [vn_pkg::M_W+1];
    vn_pkg::t_item            w_item [vn_pkg::M_W+1];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= vn_pkg::THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    vn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (i_vec),
        .i_thr   (r_thr),
        .o_valid (w_v[0]),
        .i_ready (w_r[0]),
        .o_item  (w_item[0])
    );

    for (genvar g = 0; g < vn_pkg::M_W; g++) begin : g_cell
        vn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_r[g]),
            .i_item  (w_item[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_r[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    vn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[vn_pkg::M_W]),
        .o_ready (w_r[vn_pkg::M_W]),
        .i_item  (w_item[vn_pkg::M_W]),
        .o_unit  (o_unit)
    );

endmodule
